@@ design/aacm_pkg.sv @@
// ----------------------------------------------------------------------------
// aacm_pkg: shared types and constants for the axial angle circular mean
// Holds the CORDIC arctangent table, fixed-point widths, controller states
// and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aacm_pkg;

  // Default parameter values.
  localparam int MaxLinesDefault    = 1024;
  localparam int AngleBitsDefault   = 16;
  localparam int CordicStepsDefault = 16;

  // Number of entries in the arctangent table.
  localparam int TableLen = 24;

  // Fixed-point widths: input code, sums, CORDIC x/y (Q23 grown), CORDIC z.
  localparam int CodeW = 16;
  localparam int SumW  = 27;
  localparam int Q15W  = 16;
  localparam int XyW   = 38;
  localparam int ZW    = 34;
  localparam int DegW  = 19;
  localparam int PhaseW = 32;

  // CORDIC start value and quarter turn in units of 2^-32 turn.
  localparam logic signed [XyW-1:0] CordicX0    = XyW'(64'sd5094007);
  localparam logic signed [ZW-1:0]  QuarterTurn = ZW'(64'sd1073741824);

  // Result for a set without lines: -999 degrees in Q8.
  localparam logic signed [DegW-1:0] EmptyQ8 = DegW'(-64'sd255744);

  // Q15 clamp limit.
  localparam logic signed [Q15W-1:0] Q15Max = 16'sd32767;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_ACCUM,
    ST_FINAL,
    ST_VECTOR,
    ST_RESULT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_rot;  // capture request angle, start sine/cosine rotation
    logic step;      // one CORDIC iteration
    logic accum;     // add sine/cosine into the sums, count the line
    logic load_vec;  // start atan2 vectoring from the sums, clear the set
    logic emit;      // write the result register
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic below_max;  // line count still below its limit
    logic empty;      // no lines in the current set
    logic sums_zero;  // both sums are zero
  } sts_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [30:0] atan_turn(input logic [4:0] idx);
    logic [30:0] v;
    case (idx)
      5'd0:    v = 31'd536870912;
      5'd1:    v = 31'd316933405;
      5'd2:    v = 31'd167458907;
      5'd3:    v = 31'd85004756;
      5'd4:    v = 31'd42667331;
      5'd5:    v = 31'd21354465;
      5'd6:    v = 31'd10679838;
      5'd7:    v = 31'd5340245;
      5'd8:    v = 31'd2670163;
      5'd9:    v = 31'd1335087;
      5'd10:   v = 31'd667544;
      5'd11:   v = 31'd333772;
      5'd12:   v = 31'd166886;
      5'd13:   v = 31'd83443;
      5'd14:   v = 31'd41722;
      5'd15:   v = 31'd20861;
      5'd16:   v = 31'd10430;
      5'd17:   v = 31'd5215;
      5'd18:   v = 31'd2608;
      5'd19:   v = 31'd1304;
      5'd20:   v = 31'd652;
      5'd21:   v = 31'd326;
      5'd22:   v = 31'd163;
      5'd23:   v = 31'd81;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ design/aacm_ctrl.sv @@
// ----------------------------------------------------------------------------
// aacm_ctrl: controller for the axial angle circular mean
// Sequences request capture, CORDIC iterations, accumulation, the final
// atan2 and the output register handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aacm_ctrl #(
  parameter int N_STEPS = aacm_pkg::CordicStepsDefault,
  parameter int STEP_W  = $clog2(N_STEPS)
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 has_line,
  input  wire                 set_last,
  output logic                out_valid,
  input  wire                 out_ready,
  output aacm_pkg::cmd_t      cmd,
  input  aacm_pkg::sts_t      sts,
  output logic [STEP_W-1:0]   step_idx
);

  localparam logic [STEP_W-1:0] LastStep = STEP_W'(N_STEPS - 1);

  aacm_pkg::state_t  state, state_next;
  logic [STEP_W-1:0] step_idx_next;
  logic              last, last_next;
  logic              out_valid_next;

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= aacm_pkg::ST_IDLE;
      step_idx  <= '0;
      last      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_idx  <= step_idx_next;
      last      <= last_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    step_idx_next  = step_idx;
    last_next      = last;
    out_valid_next = out_valid & ~out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    case (state)
      aacm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_rot  = 1'b1;
          last_next     = set_last;
          step_idx_next = '0;
          if (has_line && sts.below_max) begin
            state_next = aacm_pkg::ST_ROTATE;
          end else if (set_last) begin
            state_next = aacm_pkg::ST_FINAL;
          end
        end
      end
      aacm_pkg::ST_ROTATE: begin
        cmd.step      = 1'b1;
        step_idx_next = step_idx + 1'b1;
        if (step_idx == LastStep) begin
          step_idx_next = '0;
          state_next    = aacm_pkg::ST_ACCUM;
        end
      end
      aacm_pkg::ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = last ? aacm_pkg::ST_FINAL : aacm_pkg::ST_IDLE;
      end
      aacm_pkg::ST_FINAL: begin
        cmd.load_vec  = 1'b1;
        step_idx_next = '0;
        if (sts.empty || sts.sums_zero) begin
          state_next = aacm_pkg::ST_RESULT;
        end else begin
          state_next = aacm_pkg::ST_VECTOR;
        end
      end
      aacm_pkg::ST_VECTOR: begin
        cmd.step      = 1'b1;
        step_idx_next = step_idx + 1'b1;
        if (step_idx == LastStep) begin
          step_idx_next = '0;
          state_next    = aacm_pkg::ST_RESULT;
        end
      end
      aacm_pkg::ST_RESULT: begin
        // Wait until the output register is free.
        if (!out_valid || out_ready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = aacm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = aacm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/aacm_datapath.sv @@
// ----------------------------------------------------------------------------
// aacm_datapath: datapath for the axial angle circular mean
// One shared CORDIC unit (rotation for sine/cosine, vectoring for atan2),
// the sine and cosine sums, the line counter and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aacm_datapath #(
  parameter int MAX_LINES  = aacm_pkg::MaxLinesDefault,
  parameter int ANGLE_BITS = aacm_pkg::AngleBitsDefault,
  parameter int STEP_W     = 4
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire  [aacm_pkg::CodeW-1:0]           theta_code,
  input  aacm_pkg::cmd_t                       cmd,
  output aacm_pkg::sts_t                       sts,
  input  wire  [STEP_W-1:0]                    step_idx,
  output logic signed [aacm_pkg::DegW-1:0]     mean_degree,
  output logic                                 set_empty
);

  localparam int CntW       = $clog2(MAX_LINES + 1);
  localparam int PhaseShift = aacm_pkg::PhaseW - ANGLE_BITS;
  localparam logic [63:0] AngleMask64 = (64'd1 << ANGLE_BITS) - 64'd1;
  localparam logic [aacm_pkg::CodeW-1:0] AngleMask = AngleMask64[aacm_pkg::CodeW-1:0];
  localparam int XyW = aacm_pkg::XyW;
  localparam int ZW  = aacm_pkg::ZW;
  localparam int PW  = ZW + 6;

  // Rounds a Q23 value to Q15 and clamps it to +/-32767.
  function automatic logic signed [aacm_pkg::Q15W-1:0] to_q15(
      input logic signed [XyW-1:0] v);
    logic signed [XyW-1:0] r;
    r = (v + XyW'(128)) >>> 8;
    if (r > XyW'(aacm_pkg::Q15Max)) begin
      return aacm_pkg::Q15Max;
    end else if (r < -XyW'(aacm_pkg::Q15Max)) begin
      return -aacm_pkg::Q15Max;
    end
    return r[aacm_pkg::Q15W-1:0];
  endfunction

  logic signed [XyW-1:0]            x, y;
  logic signed [ZW-1:0]             z;
  logic                             vec_mode;
  logic [1:0]                       quad;
  logic signed [aacm_pkg::SumW-1:0] sine_sum, cosine_sum;
  logic [CntW-1:0]                  line_count;

  // Phase of the doubled angle in units of 2^-32 turn.
  logic [aacm_pkg::CodeW-1:0]  code_masked;
  logic [aacm_pkg::PhaseW-1:0] phase;
  assign code_masked = theta_code & AngleMask;
  assign phase = {{(aacm_pkg::PhaseW - aacm_pkg::CodeW){1'b0}}, code_masked} << PhaseShift;

  // One CORDIC iteration; both modes share the add/subtract direction.
  logic signed [XyW-1:0] sx, sy, x_step, y_step;
  logic signed [ZW-1:0]  ang, z_step;
  logic                  dir_pos;
  always_comb begin
    sx  = x >>> step_idx;
    sy  = y >>> step_idx;
    ang = signed'(ZW'(aacm_pkg::atan_turn(5'(step_idx))));
    dir_pos = vec_mode ? !(y > 0) : !z[ZW-1];
    if (dir_pos) begin
      x_step = x - sy;
      y_step = y + sx;
      z_step = z - ang;
    end else begin
      x_step = x + sy;
      y_step = y - sx;
      z_step = z + ang;
    end
  end

  // Vectoring start: sums scaled by 256, folded into the right half-plane.
  logic signed [XyW-1:0] sv, cv, xv, yv;
  logic signed [ZW-1:0]  zv;
  always_comb begin
    sv = XyW'(sine_sum) <<< 8;
    cv = XyW'(cosine_sum) <<< 8;
    if (sts.sums_zero) begin
      xv = '0;
      yv = '0;
      zv = '0;
    end else if (cv < 0) begin
      if (sv >= 0) begin
        xv = sv;
        yv = -cv;
        zv = aacm_pkg::QuarterTurn;
      end else begin
        xv = -sv;
        yv = cv;
        zv = -aacm_pkg::QuarterTurn;
      end
    end else begin
      xv = cv;
      yv = sv;
      zv = '0;
    end
  end

  // Sine and cosine of the rotation result, placed in their quadrant.
  logic signed [aacm_pkg::Q15W-1:0] xq, yq, sin_q, cos_q;
  always_comb begin
    xq = to_q15(x);
    yq = to_q15(y);
    case (quad)
      2'd0: begin
        cos_q = xq;
        sin_q = yq;
      end
      2'd1: begin
        cos_q = -yq;
        sin_q = xq;
      end
      2'd2: begin
        cos_q = -xq;
        sin_q = -yq;
      end
      default: begin
        cos_q = yq;
        sin_q = -xq;
      end
    endcase
  end

  // Degrees in Q8 from the turn angle: floor((z * 45 + 2^21) / 2^22).
  logic signed [PW-1:0] z_ext, prod, deg_full;
  always_comb begin
    z_ext    = PW'(z);
    prod     = (z_ext <<< 5) + (z_ext <<< 3) + (z_ext <<< 2) + z_ext;
    deg_full = (prod + PW'(64'sd2097152)) >>> 22;
  end

  // Status toward the controller.
  assign sts.below_max = line_count < CntW'(MAX_LINES);
  assign sts.empty     = line_count == '0;
  assign sts.sums_zero = (sine_sum == '0) && (cosine_sum == '0);

  // CORDIC registers.
  always_ff @(posedge clk) begin
    if (cmd.load_rot) begin
      vec_mode <= 1'b0;
      quad     <= phase[aacm_pkg::PhaseW-1 -: 2];
      x        <= aacm_pkg::CordicX0;
      y        <= '0;
      z        <= ZW'(phase[aacm_pkg::PhaseW-3:0]);
    end else if (cmd.load_vec) begin
      vec_mode <= 1'b1;
      x        <= xv;
      y        <= yv;
      z        <= zv;
    end else if (cmd.step) begin
      x <= x_step;
      y <= y_step;
      z <= z_step;
    end
  end

  // Sums and line count; cleared when the final angle is started.
  always_ff @(posedge clk) begin
    if (rst || cmd.load_vec) begin
      sine_sum   <= '0;
      cosine_sum <= '0;
      line_count <= '0;
    end else if (cmd.accum) begin
      sine_sum   <= sine_sum + aacm_pkg::SumW'(sin_q);
      cosine_sum <= cosine_sum + aacm_pkg::SumW'(cos_q);
      line_count <= line_count + 1'b1;
    end
  end

  // Empty flag of the set being finished, and the result register.
  logic empty_set;
  always_ff @(posedge clk) begin
    if (cmd.load_vec) begin
      empty_set <= sts.empty;
    end
    if (cmd.emit) begin
      set_empty   <= empty_set;
      mean_degree <= empty_set ? aacm_pkg::EmptyQ8 : deg_full[aacm_pkg::DegW-1:0];
    end
  end

endmodule

`default_nettype wire

@@ design/axial_angle_circular_mean.sv @@
// Sequence: a request with a line is captured, rotated through the CORDIC steps and accumulated;
// a last request then starts atan2, runs the vectoring steps and writes the result, or skips
// the vectoring when the set is empty or its sums are zero. A request without a line that is
// not last is taken in idle. Flow: one request at a time; in_ready is low while the shared CORDIC is busy.
// Reset: synchronous; clears the controller, output valid, sums and line count.
// ----------------------------------------------------------------------------
// axial_angle_circular_mean: mean direction of a set of line angles
// Doubles each axial angle, sums its sine and cosine, and on the last request
// of a set returns half of atan2 of the sums in degrees, signed Q8.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module axial_angle_circular_mean #(
  parameter int MAX_LINES    = aacm_pkg::MaxLinesDefault,
  parameter int ANGLE_BITS   = aacm_pkg::AngleBitsDefault,
  parameter int CORDIC_STEPS = aacm_pkg::CordicStepsDefault
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [aacm_pkg::CodeW-1:0]       theta_code,
  input  wire                              has_line,
  input  wire                              set_last,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [aacm_pkg::DegW-1:0] mean_degree,
  output logic                             set_empty
);

  localparam int NSteps = (CORDIC_STEPS > aacm_pkg::TableLen) ?
                          aacm_pkg::TableLen : CORDIC_STEPS;
  localparam int StepW  = $clog2(NSteps);

  aacm_pkg::cmd_t   cmd;
  aacm_pkg::sts_t   sts;
  logic [StepW-1:0] step_idx;

  // Controller.
  aacm_ctrl #(
    .N_STEPS (NSteps),
    .STEP_W  (StepW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .has_line  (has_line),
    .set_last  (set_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts),
    .step_idx  (step_idx)
  );

  // Datapath.
  aacm_datapath #(
    .MAX_LINES  (MAX_LINES),
    .ANGLE_BITS (ANGLE_BITS),
    .STEP_W     (StepW)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .theta_code  (theta_code),
    .cmd         (cmd),
    .sts         (sts),
    .step_idx    (step_idx),
    .mean_degree (mean_degree),
    .set_empty   (set_empty)
  );

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for axial_angle_circular_mean
// Sends line angles in sets and checks every set mean against a predictor
// that works through the same fixed-point CORDIC sine/cosine and atan2 steps.
// Random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int LineLimit   = aacm_pkg::MaxLinesDefault;
  localparam int Steps       = aacm_pkg::CordicStepsDefault;
  localparam int TargetCount = 1450;
  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 60;

  typedef struct packed {
    logic [aacm_pkg::CodeW-1:0] code;
    logic                       line;
    logic                       last;
  } angle_req_t;

  typedef struct packed {
    logic signed [aacm_pkg::DegW-1:0] deg;
    logic                             empty;
  } mean_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [aacm_pkg::CodeW-1:0]       theta_code = '0;
  logic                             has_line = 1'b0;
  logic                             set_last = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [aacm_pkg::DegW-1:0] mean_degree;
  logic                             set_empty;

  // Requests waiting to be sent and set means waiting to come back.
  angle_req_t   angle_reqs[$];
  mean_result_t expected_means[$];

  // Predictor state for the set in progress.
  longint sine_acc;
  longint cosine_acc;
  int     lines_held;
  longint atan_tab [0:23];

  int cycles = 0;
  int errors;
  int n_requests;
  int n_sets;
  int n_empty;
  int n_dropped;
  int n_checked;
  int n_counted;
  int in_gap;
  int out_stall;
  logic in_burst;
  logic out_burst;
  logic [aacm_pkg::CodeW-1:0] zero_sine_code;

  axial_angle_circular_mean dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .theta_code (theta_code),
    .has_line   (has_line),
    .set_last   (set_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mean_degree(mean_degree),
    .set_empty  (set_empty)
  );

  always #5 clk = ~clk;

  // Rounds a Q23 CORDIC value to Q15 and clamps it to the symmetric range.
  function automatic longint round_q15(input longint v);
    longint r;
    r = (v + 128) >>> 8;
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return r;
  endfunction

  // Sine and cosine of the doubled line angle by rotation-mode CORDIC.
  task automatic line_sincos(input logic [aacm_pkg::CodeW-1:0] code, output longint s,
                             output longint c);
    logic [aacm_pkg::PhaseW-1:0] phase;
    longint x;
    longint y;
    longint z;
    longint nx;
    phase = {code, {(aacm_pkg::PhaseW - aacm_pkg::CodeW){1'b0}}};
    x = 5094007;
    y = 0;
    z = longint'(phase[aacm_pkg::PhaseW-3:0]);
    for (int i = 0; i < Steps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_tab[i];
      end
      x = nx;
    end
    x = round_q15(x);
    y = round_q15(y);
    case (phase[aacm_pkg::PhaseW-1:aacm_pkg::PhaseW-2])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  // Angle of the summed vector in 2^-32 turn by vectoring-mode CORDIC.
  function automatic longint sum_angle(input longint sv, input longint cv);
    longint x;
    longint y;
    longint z;
    longint nx;
    if (sv == 0 && cv == 0) return 0;
    sv = sv * 256;
    cv = cv * 256;
    z = 0;
    // Fold the left half plane onto the right one with a quarter turn.
    if (cv < 0) begin
      if (sv >= 0) begin
        x = sv; y = -cv; z = 64'sd1073741824;
      end else begin
        x = -sv; y = cv; z = -64'sd1073741824;
      end
    end else begin
      x = cv; y = sv;
    end
    for (int i = 0; i < Steps; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_tab[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_tab[i];
      end
      x = nx;
    end
    return z;
  endfunction

  // Sign-extends a running sum from the block's sum width.
  function automatic longint wrap_acc(input longint v);
    logic signed [aacm_pkg::SumW-1:0] t;
    t = v[aacm_pkg::SumW-1:0];
    return longint'(t);
  endfunction

  // Folds one accepted request into the set and predicts the mean on the last one.
  task automatic fold_request(input logic [aacm_pkg::CodeW-1:0] code, input logic line,
                              input logic last);
    longint s;
    longint c;
    longint z;
    longint deg;
    mean_result_t r;
    if (line && lines_held < LineLimit) begin
      line_sincos(code, s, c);
      sine_acc   = wrap_acc(sine_acc + s);
      cosine_acc = wrap_acc(cosine_acc + c);
      lines_held++;
    end else if (line) begin
      n_dropped++;
    end
    if (last) begin
      r.empty = (lines_held == 0);
      if (r.empty) begin
        r.deg = aacm_pkg::EmptyQ8;
        n_empty++;
      end else begin
        z = sum_angle(sine_acc, cosine_acc);
        deg = (z * 45 + (64'sd1 <<< 21)) >>> 22;
        r.deg = deg[aacm_pkg::DegW-1:0];
      end
      expected_means = {expected_means, r};
      n_sets++;
      sine_acc   = 0;
      cosine_acc = 0;
      lines_held = 0;
    end
  endtask

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [aacm_pkg::CodeW-1:0] pick_code(
      input int mode, input logic [aacm_pkg::CodeW-1:0] base);
    case (mode)
      0: return aacm_pkg::CodeW'($urandom);
      1: return base + aacm_pkg::CodeW'($urandom_range(0, 2047)) - aacm_pkg::CodeW'(1024);
      default: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return '1;
          2: return 16'h8000;
          3: return 16'h7FFF;
          default: return aacm_pkg::CodeW'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic add_req(input logic [aacm_pkg::CodeW-1:0] code, input logic line,
                         input logic last);
    angle_req_t q;
    q.code = code;
    q.line = line;
    q.last = last;
    angle_reqs = {angle_reqs, q};
    if (line || last) n_counted++;
  endtask

  // One random set: up to twenty lines, some ignored requests mixed in, and a closing request.
  task automatic add_random_set();
    int n;
    int r;
    int mode;
    logic [aacm_pkg::CodeW-1:0] base;
    logic closes;
    r = $urandom_range(0, 99);
    if (r < 10) n = 0;
    else if (r < 85) n = $urandom_range(1, 6);
    else n = $urandom_range(7, 20);
    mode = $urandom_range(0, 2);
    base = aacm_pkg::CodeW'($urandom);
    closes = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) add_req(aacm_pkg::CodeW'($urandom), 1'b0, 1'b0);
      add_req(pick_code(mode, base), 1'b1, closes && (i == n - 1));
    end
    if (!closes || n == 0) add_req(aacm_pkg::CodeW'($urandom), 1'b0, 1'b1);
  endtask

  // Request driver: presents queued requests with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
      in_burst <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_gap != 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (angle_reqs.size() != 0) begin
        theta_code <= angle_reqs[0].code;
        has_line   <= angle_reqs[0].line;
        set_last   <= angle_reqs[0].last;
        in_valid   <= 1'b1;
        void'(angle_reqs.pop_front());
        if ($urandom_range(0, 39) == 0) in_burst <= ~in_burst;
        in_gap <= in_burst ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls of ready, with stretches where it stays high.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
      out_burst <= 1'b0;
    end else if (out_stall != 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 59) == 0) out_burst <= ~out_burst;
      if (!out_burst && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        out_stall <= pick_gap();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on accepted requests and checks accepted results.
  always @(posedge clk) begin : monitor
    mean_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        n_requests++;
        fold_request(theta_code, has_line, set_last);
      end
      if (out_valid && out_ready) begin
        if (expected_means.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: deg %0d empty %0b", mean_degree, set_empty);
        end else begin
          want = expected_means.pop_front();
          n_checked++;
          if (mean_degree !== want.deg || set_empty !== want.empty) begin
            errors++;
            if (errors <= 10)
              $display("mismatch on set %0d: expected deg %0d empty %0b, got deg %0d empty %0b",
                       n_checked, want.deg, want.empty, mean_degree, set_empty);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    logic long_done;
    longint s;
    longint c;
    atan_tab = '{64'd536870912, 64'd316933405, 64'd167458907, 64'd85004756,
                 64'd42667331, 64'd21354465, 64'd10679838, 64'd5340245,
                 64'd2670163, 64'd1335087, 64'd667544, 64'd333772,
                 64'd166886, 64'd83443, 64'd41722, 64'd20861,
                 64'd10430, 64'd5215, 64'd2608, 64'd1304,
                 64'd652, 64'd326, 64'd163, 64'd81};
    errors = 0;
    n_requests = 0;
    n_sets = 0;
    n_empty = 0;
    n_dropped = 0;
    n_checked = 0;
    n_counted = 0;
    sine_acc = 0;
    cosine_acc = 0;
    lines_held = 0;

    // Find a line whose doubled angle gives a zero sine and a negative cosine.
    zero_sine_code = 16'h8000;
    for (int k = 16'h8000; k < 16'hC000; k++) begin
      line_sincos(aacm_pkg::CodeW'(k), s, c);
      if (s == 0 && c < 0) begin
        zero_sine_code = aacm_pkg::CodeW'(k);
        break;
      end
    end

    // Directed: empty set, field extremes, single lines on each axis.
    add_req(16'hFFFF, 1'b0, 1'b1);
    add_req(16'h0000, 1'b1, 1'b1);
    add_req(16'hFFFF, 1'b1, 1'b1);
    add_req(16'h8000, 1'b1, 1'b1);
    add_req(16'h4000, 1'b1, 1'b1);
    add_req(16'hC000, 1'b1, 1'b1);
    // Ignored request inside a set, closed by a request without a line.
    add_req(16'h1234, 1'b0, 1'b0);
    add_req(16'h5678, 1'b1, 1'b0);
    add_req(16'h0000, 1'b0, 1'b1);
    // Perpendicular lines cancel: zero sums with lines present.
    add_req(16'h1234, 1'b1, 1'b0);
    add_req(16'h9234, 1'b1, 1'b1);
    // Zero sine sum with a negative cosine sum lands on plus ninety degrees.
    add_req(zero_sine_code, 1'b1, 1'b1);
    // Only ignored requests before the close: still an empty set.
    add_req(16'hAAAA, 1'b0, 1'b0);
    add_req(16'h5555, 1'b0, 1'b1);
    // Last request carries a line after others.
    add_req(16'h2000, 1'b1, 1'b0);
    add_req(16'h2100, 1'b1, 1'b1);

    // Random sets, with one set that runs past the line limit.
    long_done = 1'b0;
    while (n_counted < TargetCount) begin
      if (!long_done && n_counted > 500) begin
        for (int i = 0; i < LineLimit + 5; i++)
          add_req(aacm_pkg::CodeW'($urandom), 1'b1, 1'b0);
        add_req(aacm_pkg::CodeW'($urandom), 1'b1, 1'b1);
        long_done = 1'b1;
      end else begin
        add_random_set();
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (angle_reqs.size() != 0 || in_valid || expected_means.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (expected_means.size() != 0) begin
      errors += expected_means.size();
      $display("%0d set means never arrived", expected_means.size());
    end
    $display("sent %0d requests in %0d sets (%0d empty), checked %0d means",
             n_requests, n_sets, n_empty, n_checked);
    $display("lines past the limit dropped: %0d, failures: %0d", n_dropped, errors);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/aacm_pkg.sv
design/aacm_ctrl.sv
design/aacm_datapath.sv
design/axial_angle_circular_mean.sv
sim/testbench.sv
